FILE: rtl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define TLI_ASSERT_HOLD(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("interpolator check failed");

// Next-cycle implication.
`define TLI_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("interpolator check failed");

`endif

FILE: rtl/tli_pkg.sv
`default_nettype none

package tli_pkg;

    localparam int TABLE_DEPTH_DEF = 256;
    localparam int CFG_ADDR_W      = 3;
    localparam int CFG_DATA_W      = 32;
    localparam int COUNT_W         = 9;

    // word select bit of paddr
    localparam logic REG_ENTRIES = 1'b0;

    typedef enum logic {
        CMD_LOAD  = 1'b0,
        CMD_QUERY = 1'b1
    } cmd_code_t;

    typedef enum logic [1:0] {
        STATUS_OK    = 2'd0,
        STATUS_EMPTY = 2'd1,
        STATUS_FAIL  = 2'd2
    } status_t;

    typedef struct packed {
        cmd_code_t          command;
        logic [7:0]         entry_index;
        logic signed [31:0] entry_x;
        logic signed [31:0] entry_y;
        logic signed [31:0] query_x;
    } request_t;

    typedef struct packed {
        logic signed [31:0] value;
        status_t            status;
    } result_t;

endpackage

`default_nettype wire

FILE: rtl/table_linear_interpolator_core.sv
// Piecewise linear interpolator over a breakpoint table held in two synchronous
// memories (x and y, two read ports each). A load is written when it is taken and
// leaves busy low. A query on an empty table answers in the cycle after it is taken
// and leaves busy low; a query at or beyond either table end answers from S_ENDS
// once the end entries are read. An interior query runs a binary search (at most
// floor(log2(n-1))+1 probes, 8 for 256 entries), then a restoring divider, one
// quotient bit per cycle. A quotient too large for the output skips the divider and
// a failed search returns early. busy is high from the cycle after a non-empty query
// is taken until its result appears. The result shows on result for exactly one
// cycle with done high and cannot be held off, so the receiver must take it then.
`default_nettype none

`include "assert_macros.svh"

module table_linear_interpolator_core
    import tli_pkg::*;
#(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [CFG_ADDR_W-1:0] paddr,
    input  wire logic [CFG_DATA_W-1:0] pwdata,
    output logic      [CFG_DATA_W-1:0] prdata,
    output logic                       pready,
    input  wire logic                  start,
    output logic                       busy,
    input  wire request_t              request,
    output logic                       done,
    output result_t                    result
);

    localparam int AW        = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int NW        = AW + 1;
    localparam int CW        = (NW > COUNT_W) ? NW : COUNT_W;
    localparam int XW        = 32;
    localparam int DW        = XW + 1;
    localparam int PW        = 2 * DW;
    localparam int MW        = DW + 1;
    localparam int SW        = MW + 1;
    localparam int DIV_STEPS = DW;
    localparam int CNTW      = $clog2(DIV_STEPS + 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_ENDS,
        S_SEARCH,
        S_PROBE,
        S_MUL,
        S_DIVCHK,
        S_DIV,
        S_SUM
    } state_t;

    state_t                 state_reg, state_next;
    logic [COUNT_W-1:0]     entries_in_use_reg;
    logic signed [XW-1:0]   q_reg, q_next;
    logic signed [AW:0]     lo_reg, lo_next;
    logic signed [AW:0]     hi_reg, hi_next;
    logic [AW-1:0]          mid_reg, mid_next;
    logic                   last_reg, last_next;
    logic                   neg_reg, neg_next;
    logic [DW-1:0]          dy_mag_reg, dy_mag_next;
    logic [DW-1:0]          off_mag_reg, off_mag_next;
    logic [DW-1:0]          dx_mag_reg, dx_mag_next;
    logic signed [XW-1:0]   y0_reg, y0_next;
    logic [PW-1:0]          prod_reg, prod_next;
    logic [DW-1:0]          rem_reg, rem_next;
    logic [DW-1:0]          quo_reg, quo_next;
    logic [CNTW-1:0]        cnt_reg, cnt_next;
    logic                   sat_reg, sat_next;
    logic                   done_reg, done_next;
    result_t                result_reg, result_next;

    logic [XW-1:0]          x_mem [TABLE_DEPTH];
    logic [XW-1:0]          y_mem [TABLE_DEPTH];
    logic signed [XW-1:0]   xa_reg, xb_reg, ya_reg, yb_reg;

    logic [NW-1:0]          n_cur;
    logic                   load_we;
    logic                   query_take;
    logic [AW-1:0]          addr_a, addr_b;
    logic [NW:0]            lohi_sum;
    logic [AW-1:0]          mid_calc;
    logic                   cfg_we;

    logic signed [DW-1:0]   dx_w, dy_w, off_w;
    logic                   hit;
    logic [MW-1:0]          rem_sh;
    logic [MW-1:0]          mag_w;
    logic signed [SW-1:0]   sum_w;

    assign pready = 1'b1;
    assign busy   = (state_reg != S_IDLE);
    assign done   = done_reg;
    assign result = result_reg;

    assign cfg_we = psel && penable && pwrite && pready
                    && (paddr[CFG_ADDR_W-1:2] == REG_ENTRIES);

    always_comb
    begin
        prdata = '0;
        if (paddr[CFG_ADDR_W-1:2] == REG_ENTRIES)
        begin
            prdata = CFG_DATA_W'(entries_in_use_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entries_in_use_reg <= '0;
        end
        else if (cfg_we)
        begin
            entries_in_use_reg <= pwdata[COUNT_W-1:0];
        end
    end

    assign n_cur = (CW'(entries_in_use_reg) > CW'(TABLE_DEPTH)) ? NW'(TABLE_DEPTH)
                                                                 : NW'(entries_in_use_reg);

    assign load_we    = start && !busy && (request.command == CMD_LOAD)
                        && (CW'(request.entry_index) < CW'(TABLE_DEPTH));
    assign query_take = start && !busy && (request.command == CMD_QUERY);

    assign lohi_sum = {lo_reg[AW], lo_reg} + {hi_reg[AW], hi_reg};
    assign mid_calc = lohi_sum[AW:1];

    always_comb
    begin
        unique case (state_reg)
            S_IDLE:
            begin
                addr_a = '0;
                addr_b = AW'(n_cur - NW'(1));
            end
            S_SEARCH:
            begin
                addr_a = (lo_reg == hi_reg) ? lo_reg[AW-1:0] : mid_calc;
                addr_b = addr_a + AW'(1);
            end
            default:
            begin
                addr_a = mid_reg;
                addr_b = mid_reg + AW'(1);
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (load_we)
        begin
            x_mem[AW'(request.entry_index)] <= request.entry_x;
            y_mem[AW'(request.entry_index)] <= request.entry_y;
        end
        xa_reg <= x_mem[addr_a];
        xb_reg <= x_mem[addr_b];
        ya_reg <= y_mem[addr_a];
        yb_reg <= y_mem[addr_b];
    end

    assign dx_w  = DW'(xb_reg) - DW'(xa_reg);
    assign dy_w  = DW'(yb_reg) - DW'(ya_reg);
    assign off_w = DW'(q_reg) - DW'(xa_reg);
    assign hit   = (xa_reg <= q_reg) && (q_reg < xb_reg);

    assign rem_sh = {rem_reg, quo_reg[DW-1]};
    assign mag_w  = sat_reg ? (MW'(1) << DW) : MW'(quo_reg);
    assign sum_w  = (SW'(y0_reg)) + (neg_reg ? -$signed(SW'(mag_w)) : $signed(SW'(mag_w)));

    always_comb
    begin
        state_next   = state_reg;
        q_next       = q_reg;
        lo_next      = lo_reg;
        hi_next      = hi_reg;
        mid_next     = mid_reg;
        last_next    = last_reg;
        neg_next     = neg_reg;
        dy_mag_next  = dy_mag_reg;
        off_mag_next = off_mag_reg;
        dx_mag_next  = dx_mag_reg;
        y0_next      = y0_reg;
        prod_next    = prod_reg;
        rem_next     = rem_reg;
        quo_next     = quo_reg;
        cnt_next     = cnt_reg;
        sat_next     = sat_reg;
        done_next    = 1'b0;
        result_next  = result_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (query_take)
                begin
                    q_next = request.query_x;
                    if (n_cur == '0)
                    begin
                        done_next          = 1'b1;
                        result_next.value  = '0;
                        result_next.status = STATUS_EMPTY;
                    end
                    else
                    begin
                        state_next = S_ENDS;
                    end
                end
            end
            S_ENDS:
            begin
                if (q_reg <= xa_reg)
                begin
                    state_next         = S_IDLE;
                    done_next          = 1'b1;
                    result_next.value  = ya_reg;
                    result_next.status = STATUS_OK;
                end
                else if (q_reg >= xb_reg)
                begin
                    state_next         = S_IDLE;
                    done_next          = 1'b1;
                    result_next.value  = yb_reg;
                    result_next.status = STATUS_OK;
                end
                else
                begin
                    lo_next    = '0;
                    hi_next    = n_cur - NW'(2);
                    state_next = S_SEARCH;
                end
            end
            S_SEARCH:
            begin
                if (lo_reg > hi_reg)
                begin
                    state_next         = S_IDLE;
                    done_next          = 1'b1;
                    result_next.value  = '0;
                    result_next.status = STATUS_FAIL;
                end
                else
                begin
                    mid_next   = addr_a;
                    last_next  = (lo_reg == hi_reg);
                    state_next = S_PROBE;
                end
            end
            S_PROBE:
            begin
                if (last_reg || hit)
                begin
                    if (dx_w == '0)
                    begin
                        state_next         = S_IDLE;
                        done_next          = 1'b1;
                        result_next.value  = '0;
                        result_next.status = STATUS_FAIL;
                    end
                    else
                    begin
                        neg_next     = dy_w[DW-1] ^ off_w[DW-1] ^ dx_w[DW-1];
                        dy_mag_next  = dy_w[DW-1] ? DW'(-dy_w) : DW'(dy_w);
                        off_mag_next = off_w[DW-1] ? DW'(-off_w) : DW'(off_w);
                        dx_mag_next  = dx_w[DW-1] ? DW'(-dx_w) : DW'(dx_w);
                        y0_next      = ya_reg;
                        state_next   = S_MUL;
                    end
                end
                else if (q_reg < xa_reg)
                begin
                    hi_next    = {1'b0, mid_reg} - NW'(1);
                    state_next = S_SEARCH;
                end
                else
                begin
                    lo_next    = {1'b0, mid_reg} + NW'(1);
                    state_next = S_SEARCH;
                end
            end
            S_MUL:
            begin
                prod_next  = PW'(dy_mag_reg) * PW'(off_mag_reg);
                state_next = S_DIVCHK;
            end
            S_DIVCHK:
            begin
                if (prod_reg >= {dx_mag_reg, DW'(0)})
                begin
                    sat_next   = 1'b1;
                    state_next = S_SUM;
                end
                else
                begin
                    sat_next   = 1'b0;
                    rem_next   = prod_reg[PW-1:DW];
                    quo_next   = prod_reg[DW-1:0];
                    cnt_next   = CNTW'(DIV_STEPS);
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                if (rem_sh >= {1'b0, dx_mag_reg})
                begin
                    rem_next = DW'(rem_sh - {1'b0, dx_mag_reg});
                    quo_next = {quo_reg[DW-2:0], 1'b1};
                end
                else
                begin
                    rem_next = rem_sh[DW-1:0];
                    quo_next = {quo_reg[DW-2:0], 1'b0};
                end
                cnt_next = cnt_reg - CNTW'(1);
                if (cnt_reg == CNTW'(1))
                begin
                    state_next = S_SUM;
                end
            end
            S_SUM:
            begin
                state_next         = S_IDLE;
                done_next          = 1'b1;
                result_next.status = STATUS_OK;
                if ((sum_w[SW-1:XW-1] == '0) || (sum_w[SW-1:XW-1] == '1))
                begin
                    result_next.value = sum_w[XW-1:0];
                end
                else if (sum_w[SW-1])
                begin
                    result_next.value = {1'b1, {(XW-1){1'b0}}};
                end
                else
                begin
                    result_next.value = {1'b0, {(XW-1){1'b1}}};
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            q_reg       <= '0;
            lo_reg      <= '0;
            hi_reg      <= '0;
            mid_reg     <= '0;
            last_reg    <= 1'b0;
            neg_reg     <= 1'b0;
            dy_mag_reg  <= '0;
            off_mag_reg <= '0;
            dx_mag_reg  <= '0;
            y0_reg      <= '0;
            prod_reg    <= '0;
            rem_reg     <= '0;
            quo_reg     <= '0;
            cnt_reg     <= '0;
            sat_reg     <= 1'b0;
            done_reg    <= 1'b0;
            result_reg  <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            q_reg       <= q_next;
            lo_reg      <= lo_next;
            hi_reg      <= hi_next;
            mid_reg     <= mid_next;
            last_reg    <= last_next;
            neg_reg     <= neg_next;
            dy_mag_reg  <= dy_mag_next;
            off_mag_reg <= off_mag_next;
            dx_mag_reg  <= dx_mag_next;
            y0_reg      <= y0_next;
            prod_reg    <= prod_next;
            rem_reg     <= rem_next;
            quo_reg     <= quo_next;
            cnt_reg     <= cnt_next;
            sat_reg     <= sat_next;
            done_reg    <= done_next;
            result_reg  <= result_next;
        end
    end

    `TLI_ASSERT_HOLD(a_div_rem_below_divisor, state_reg == S_DIV, rem_reg < dx_mag_reg)
    `TLI_ASSERT_HOLD(a_probe_bounds_ordered, state_reg == S_PROBE, lo_reg <= hi_reg)
    `TLI_ASSERT_HOLD(a_done_only_when_idle, done_reg, state_reg == S_IDLE)
    `TLI_ASSERT_NEXT(a_query_raises_busy, query_take && (n_cur != '0), busy)

endmodule

`default_nettype wire

FILE: tb/testbench.sv
`default_nettype none

module testbench;
    import tli_pkg::*;

    localparam int CLK_HALF    = 10;
    localparam int STALL_LIMIT = 2000;
    localparam int GAP_CAP     = 40;
    localparam logic [CFG_ADDR_W-1:0] ENTRIES_ADDR = {REG_ENTRIES, 2'b00};

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [CFG_ADDR_W-1:0] paddr;
    logic [CFG_DATA_W-1:0] pwdata;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;
    logic                  start;
    logic                  busy;
    request_t              request;
    logic                  done;
    result_t               result;

    table_linear_interpolator_core u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .start   (start),
        .busy    (busy),
        .request (request),
        .done    (done),
        .result  (result)
    );

    logic signed [31:0] bp_x [TABLE_DEPTH_DEF];
    logic signed [31:0] bp_y [TABLE_DEPTH_DEF];
    logic [COUNT_W-1:0] entry_count = '0;
    result_t            expected_results [$];
    int                 errors       = 0;
    int                 idle_pct     = 0;
    int                 stall_cycles = 0;

    always #CLK_HALF clk = ~clk;

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("%0t %s: got %h expected %h", $time, what, got, want);
        errors++;
    endtask

    task automatic expect_result(input result_t r);
        expected_results = {expected_results, r};
    endtask

    function automatic result_t interpolate(input logic signed [31:0] qx);
        result_t             r;
        int                  n;
        int                  lo;
        int                  hi;
        int                  mid;
        int                  seg;
        bit                  searching;
        bit                  neg;
        longint              q;
        longint              x0;
        longint              y0;
        longint              dx;
        longint              dy;
        longint              off;
        longint              sum;
        longint unsigned     adx;
        longint unsigned     ady;
        longint unsigned     aoff;
        longint unsigned     mag;
        logic [127:0]        prod;
        logic [127:0]        quo;
        r.value  = '0;
        r.status = STATUS_OK;
        n = (entry_count > COUNT_W'(TABLE_DEPTH_DEF)) ? TABLE_DEPTH_DEF : int'(entry_count);
        q = longint'(qx);
        if (n == 0)
            r.status = STATUS_EMPTY;
        else if (q <= longint'(bp_x[0]))
            r.value = bp_y[0];
        else if (q >= longint'(bp_x[n-1]))
            r.value = bp_y[n-1];
        else
        begin
            lo        = 0;
            hi        = n - 2;
            seg       = -1;
            searching = 1'b1;
            while (searching)
            begin
                if (lo == hi)
                begin
                    seg       = lo;
                    searching = 1'b0;
                end
                else if (lo > hi)
                    searching = 1'b0;
                else
                begin
                    mid = (lo + hi) / 2;
                    if (longint'(bp_x[mid]) <= q && q < longint'(bp_x[mid+1]))
                    begin
                        seg       = mid;
                        searching = 1'b0;
                    end
                    else if (q < longint'(bp_x[mid]))
                        hi = mid - 1;
                    else
                        lo = mid + 1;
                end
            end
            if (seg < 0 || seg + 1 >= n)
                r.status = STATUS_FAIL;
            else
            begin
                x0 = longint'(bp_x[seg]);
                y0 = longint'(bp_y[seg]);
                dx = longint'(bp_x[seg+1]) - x0;
                if (dx == 0)
                    r.status = STATUS_FAIL;
                else
                begin
                    dy   = longint'(bp_y[seg+1]) - y0;
                    off  = q - x0;
                    neg  = ((dy < 0) != (off < 0)) != (dx < 0);
                    ady  = (dy < 0) ? -dy : dy;
                    aoff = (off < 0) ? -off : off;
                    adx  = (dx < 0) ? -dx : dx;
                    prod = 128'(ady) * 128'(aoff);
                    quo  = prod / 128'(adx);
                    mag  = (quo >= (128'd1 << 33)) ? (64'd1 << 33) : quo[63:0];
                    sum  = neg ? y0 - longint'(mag) : y0 + longint'(mag);
                    if (sum > 64'sd2147483647)
                        r.value = 32'sh7FFF_FFFF;
                    else if (sum < -64'sd2147483648)
                        r.value = 32'sh8000_0000;
                    else
                        r.value = sum[31:0];
                end
            end
        end
        return r;
    endfunction

    function automatic request_t make_load(input logic [7:0] idx, input logic [31:0] x,
                                           input logic [31:0] y);
        request_t req;
        req.command     = CMD_LOAD;
        req.entry_index = idx;
        req.entry_x     = x;
        req.entry_y     = y;
        req.query_x     = $urandom;
        return req;
    endfunction

    function automatic request_t make_query(input logic [31:0] q);
        request_t req;
        req.command     = CMD_QUERY;
        req.entry_index = 8'($urandom);
        req.entry_x     = $urandom;
        req.entry_y     = $urandom;
        req.query_x     = q;
        return req;
    endfunction

    // one transaction; start is left high so back-to-back items need no gap
    task automatic send_item(input request_t req);
        int gap;
        gap = 0;
        while (gap < GAP_CAP && $urandom_range(99) < idle_pct)
            gap++;
        if (gap > 0)
        begin
            @(negedge clk);
            start <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        else
            @(negedge clk);
        start   <= 1'b1;
        request <= req;
        do @(posedge clk); while (busy);
        if (req.command == CMD_QUERY)
            expect_result(interpolate(req.query_x));
        else
        begin
            bp_x[req.entry_index] = req.entry_x;
            bp_y[req.entry_index] = req.entry_y;
        end
    endtask

    task automatic wait_for_results();
        @(negedge clk);
        start <= 1'b0;
        while (expected_results.size() != 0 || busy)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_entry_count(input logic [COUNT_W-1:0] n);
        logic [CFG_DATA_W-1:0] rd;
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ENTRIES_ADDR;
        pwdata  <= CFG_DATA_W'(n);
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        entry_count = n;
        @(negedge clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        rd = prdata;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (rd[COUNT_W-1:0] != n)
            report_mismatch("entry count readback", rd, CFG_DATA_W'(n));
    endtask

    always @(posedge clk)
    begin : result_check
        result_t want;
        if (rst_n && done)
        begin
            if (expected_results.size() == 0)
                report_mismatch("result with no query pending", result.value, '0);
            else
            begin
                want = expected_results.pop_front();
                if (result.value !== want.value)
                    report_mismatch("value", result.value, want.value);
                if (result.status !== want.status)
                    report_mismatch("status", 32'(result.status), 32'(want.status));
            end
        end
    end

    always @(posedge clk)
    begin
        if ((start && !busy) || done || (psel && penable))
            stall_cycles = 0;
        else
            stall_cycles++;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    task automatic test_empty_table();
        write_entry_count(0);
        send_item(make_query(32'h8000_0000));
        send_item(make_query(32'h7FFF_FFFF));
        send_item(make_query(32'h0000_0000));
        send_item(make_load(8'd255, 32'h7FFF_FFFF, 32'h8000_0000));
        wait_for_results();
    endtask

    // extreme abscissae and ordinates, steep negative slopes for truncation
    task automatic test_breakpoint_segments();
        send_item(make_load(8'd0, 32'h8000_0000, 32'h7FFF_FFFF));
        send_item(make_load(8'd1, 32'hFFFF_0000, 32'h0000_0000));
        send_item(make_load(8'd2, 32'h0001_0000, 32'h8000_0000));
        send_item(make_load(8'd3, 32'h7FFF_FFFF, 32'h0000_3039));
        wait_for_results();
        write_entry_count(4);
        send_item(make_query(32'h8000_0000));
        send_item(make_query(32'h7FFF_FFFF));
        send_item(make_query(32'hFFFE_FFFF));
        send_item(make_query(32'hFFFF_7FFF));
        send_item(make_query(32'h0000_0000));
        send_item(make_query(32'h0001_0000));
        send_item(make_query(32'h0001_86A0));
        send_item(make_query(32'h7FFF_FFFE));
        wait_for_results();
    endtask

    // duplicate and out-of-order abscissae, then a single-entry table
    task automatic test_unsorted_table();
        send_item(make_load(8'd0, 32'd0,        32'd10));
        send_item(make_load(8'd1, 32'd6553600,  32'd2000000000));
        send_item(make_load(8'd2, 32'd6553600,  -32'sd2000000000));
        send_item(make_load(8'd3, 32'd3276800,  32'd7));
        send_item(make_load(8'd4, 32'd13107200, -32'sd9));
        wait_for_results();
        write_entry_count(5);
        send_item(make_query(32'd3932160));
        send_item(make_query(32'd6553600));
        send_item(make_query(32'd9830400));
        send_item(make_query(32'd13041664));
        wait_for_results();
        write_entry_count(1);
        send_item(make_query(32'd0));
        wait_for_results();
    endtask

    task automatic test_random_tables(input int budget, input int pct, input bit full_table);
        int       sent;
        int       n;
        int       m;
        int       pick;
        bit       small_scale;
        int       xs [$];
        longint   lo_x;
        longint   hi_x;
        longint   span;
        logic [31:0] q;
        logic [31:0] y;
        idle_pct = pct;
        sent     = 0;
        while (sent < budget)
        begin
            if (full_table)
            begin
                n          = TABLE_DEPTH_DEF;
                full_table = 1'b0;
            end
            else
                case ($urandom_range(3))
                    0:       n = $urandom_range(2, 1);
                    1:       n = $urandom_range(8, 3);
                    2:       n = $urandom_range(24, 9);
                    default: n = $urandom_range(64, 25);
                endcase
            small_scale = $urandom_range(1);
            xs.delete();
            for (int i = 0; i < n; i++)
                xs = {xs, (small_scale ? int'($urandom_range(1 << 21)) - (1 << 20)
                                       : int'($urandom))};
            if ($urandom_range(4) != 0)
            begin
                xs.sort();
                if (n > 2 && $urandom_range(9) == 0)
                    xs[1] = xs[2];
            end
            for (int i = 0; i < n; i++)
            begin
                y = small_scale ? 32'(int'($urandom_range(1 << 21)) - (1 << 20)) : $urandom;
                send_item(make_load(8'(i), xs[i], y));
                sent++;
            end
            wait_for_results();
            write_entry_count(COUNT_W'(n));
            m = $urandom_range(24, 8);
            for (int j = 0; j < m; j++)
            begin
                if ($urandom_range(9) == 0)
                    send_item(make_load(8'($urandom), $urandom, $urandom));
                else
                begin
                    lo_x = longint'(bp_x[0]);
                    hi_x = longint'(bp_x[n-1]);
                    pick = $urandom_range(99);
                    if (pick < 70 && hi_x > lo_x)
                    begin
                        span = hi_x - lo_x + 1;
                        q    = 32'(lo_x + longint'({$urandom, $urandom} % span));
                    end
                    else if (pick < 85)
                        q = bp_x[$urandom_range(n - 1)];
                    else
                        q = $urandom;
                    send_item(make_query(q));
                end
                sent++;
                if (j == m / 2 && $urandom_range(3) == 0)
                    wait_for_results();
            end
            wait_for_results();
        end
    endtask

    initial
    begin
        rst_n   = 1'b0;
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = '0;
        pwdata  = '0;
        start   = 1'b0;
        request = '0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_empty_table();
        test_breakpoint_segments();
        test_unsorted_table();
        test_random_tables(300, 0, 1'b1);
        test_random_tables(300, 86, 1'b0);
        test_random_tables(300, 27, 1'b0);

        wait_for_results();
        repeat (60) @(posedge clk);
        if (errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

`default_nettype wire
